### rtl/fdp_pkg.sv
package fdp_pkg;

   localparam int ACC_W   = 54;
   localparam int MANT_W  = 55;
   localparam int SCALE_W = 4;
   localparam int CHAR_W  = 8;
   localparam int DIGIT_W = 4;

   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

   localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              field_end;
   } req_type;

   typedef struct packed {
      logic signed [MANT_W-1:0] mantissa;
      logic [SCALE_W-1:0]       frac_scale;
      logic                     overflowed;
   } rsp_type;

   typedef struct packed {
      logic               is_minus;
      logic               is_point;
      logic               is_digit;
      logic [DIGIT_W-1:0] digit;
   } char_class_type;

   // field outcome including the word being taken
   typedef struct packed {
      logic [ACC_W-1:0]   magnitude;
      logic               negative;
      logic [SCALE_W-1:0] frac_scale;
      logic               overflowed;
   } field_result_type;

endpackage

### rtl/fdp_char_class.sv
module fdp_char_class (
   input  logic [fdp_pkg::CHAR_W-1:0] char_code,
   output fdp_pkg::char_class_type    char_class
);

   logic [fdp_pkg::CHAR_W-1:0] offset;

   assign offset = char_code - fdp_pkg::CHAR_ZERO;

   always_comb begin
      char_class.is_minus = (char_code == fdp_pkg::CHAR_MINUS);
      char_class.is_point = (char_code == fdp_pkg::CHAR_POINT);
      char_class.is_digit = (char_code >= fdp_pkg::CHAR_ZERO) &&
                            (char_code <= fdp_pkg::CHAR_NINE);
      char_class.digit    = offset[fdp_pkg::DIGIT_W-1:0];
   end

endmodule

### rtl/fdp_field_state.sv
module fdp_field_state #(
   parameter int MAX_FIELD_LEN = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       take,
   input  logic                       field_end,
   input  fdp_pkg::char_class_type    char_class,
   output fdp_pkg::field_result_type  result
);

   localparam int POS_W = (MAX_FIELD_LEN > 1) ? $clog2(MAX_FIELD_LEN) : 1;
   localparam int PT_W  = $clog2(MAX_FIELD_LEN + 1);
   localparam int SUM_W = fdp_pkg::ACC_W + 4;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_FIELD_LEN - 1);
   localparam logic [PT_W-1:0]  NO_POINT = PT_W'(MAX_FIELD_LEN);

   logic                      negative_ff, negative_in;
   logic                      seen_ff, seen_in;
   logic                      stopped_ff, stopped_in;
   logic                      full_ff, full_in;
   logic                      sat_ff, sat_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic [PT_W-1:0]           point_ff, point_in;
   logic [POS_W-1:0]          last_ff, last_in;
   logic [fdp_pkg::ACC_W-1:0] acc_ff, acc_in;

   logic [SUM_W-1:0] acc_wide;
   logic [SUM_W-1:0] times_ten_plus;
   logic             too_big;
   logic [PT_W-1:0]  last_wide;
   logic [PT_W-1:0]  scale_diff;

   assign acc_wide       = {4'b0, acc_ff};
   // acc * 10 + digit; anything above the accumulator width means saturation
   assign times_ten_plus = (acc_wide << 3) + (acc_wide << 1) +
                           {{(SUM_W - fdp_pkg::DIGIT_W){1'b0}}, char_class.digit};
   assign too_big        = sat_ff || (times_ten_plus[SUM_W-1:fdp_pkg::ACC_W] != 4'b0);

   always_comb begin
      negative_in = negative_ff;
      seen_in     = seen_ff;
      stopped_in  = stopped_ff;
      full_in     = full_ff;
      sat_in      = sat_ff;
      pos_in      = pos_ff;
      point_in    = point_ff;
      last_in     = last_ff;
      acc_in      = acc_ff;
      if (!full_ff && !stopped_ff) begin
         if (char_class.is_minus) begin
            negative_in = 1'b1;
         end else if (char_class.is_point) begin
            point_in = PT_W'(pos_ff);
         end else if (char_class.is_digit) begin
            if (too_big) begin
               acc_in = fdp_pkg::ACC_MAX;
               sat_in = 1'b1;
            end else begin
               acc_in = times_ten_plus[fdp_pkg::ACC_W-1:0];
            end
            seen_in = 1'b1;
            last_in = pos_ff;
         end else if (seen_ff) begin
            stopped_in = 1'b1;
         end
         if (pos_ff == LAST_POS) begin
            full_in = 1'b1;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   assign last_wide  = PT_W'(last_in);
   assign scale_diff = last_wide - point_in;

   always_comb begin
      result = '0;
      if (seen_in) begin
         result.magnitude  = acc_in;
         result.negative   = negative_in;
         result.overflowed = sat_in;
         if (point_in < last_wide) begin
            result.frac_scale = fdp_pkg::SCALE_W'(scale_diff);
         end
      end
   end

   // state returns to its reset value once the field's result has been formed
   always_ff @(posedge clock) begin
      if (reset || (take && field_end)) begin
         negative_ff <= 1'b0;
         seen_ff     <= 1'b0;
         stopped_ff  <= 1'b0;
         full_ff     <= 1'b0;
         sat_ff      <= 1'b0;
         pos_ff      <= '0;
         point_ff    <= NO_POINT;
         last_ff     <= '0;
         acc_ff      <= '0;
      end else if (take) begin
         negative_ff <= negative_in;
         seen_ff     <= seen_in;
         stopped_ff  <= stopped_in;
         full_ff     <= full_in;
         sat_ff      <= sat_in;
         pos_ff      <= pos_in;
         point_ff    <= point_in;
         last_ff     <= last_in;
         acc_ff      <= acc_in;
      end
   end

endmodule

### rtl/fixed_field_decimal_parser_unit.sv
// Decimal field parser: takes one character word per cycle, sustained unless a
// field end waits on a result, and after the word flagged field_end returns one
// word holding the signed mantissa, its decimal scale and a saturation flag. A
// character passes an input register and is folded into the field state in the
// next cycle (the times-ten-plus-digit update of the 54-bit accumulator is the
// loop that sets the rate); the result goes into an output register when the
// last character leaves the input register. While a result waits, a character
// ending a further field is held there and characters that end no field flow on.
module fixed_field_decimal_parser_unit #(
   parameter int MAX_FIELD_LEN = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fdp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fdp_pkg::rsp_type rsp_data
);

   logic             in_valid_ff, in_valid_in;
   fdp_pkg::req_type in_word_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [fdp_pkg::ACC_W-1:0]   mag_ff;
   logic                        neg_ff;
   logic [fdp_pkg::SCALE_W-1:0] scale_ff;
   logic                        ovf_ff;

   logic                      advance;
   logic                      load_result;
   fdp_pkg::char_class_type   char_class;
   fdp_pkg::field_result_type field_result;
   logic [fdp_pkg::MANT_W-1:0] mag_wide;

   assign advance     = in_valid_ff &&
                        (!in_word_ff.field_end || !rsp_valid_ff || rsp_ready);
   assign load_result = advance && in_word_ff.field_end;
   assign req_ready   = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_data;
      end
      if (load_result) begin
         mag_ff   <= field_result.magnitude;
         neg_ff   <= field_result.negative;
         scale_ff <= field_result.frac_scale;
         ovf_ff   <= field_result.overflowed;
      end
   end

   fdp_char_class u_char_class (
      .char_code  (in_word_ff.char_code),
      .char_class (char_class)
   );

   fdp_field_state #(
      .MAX_FIELD_LEN (MAX_FIELD_LEN)
   ) u_field_state (
      .clock      (clock),
      .reset      (reset),
      .take       (advance),
      .field_end  (in_word_ff.field_end),
      .char_class (char_class),
      .result     (field_result)
   );

   assign mag_wide  = {1'b0, mag_ff};
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_data.mantissa   = neg_ff ? -$signed(mag_wide) : $signed(mag_wide);
      rsp_data.frac_scale = scale_ff;
      rsp_data.overflowed = ovf_ff;
   end

   // a finished field never overwrites a result still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_result |-> (!rsp_valid_ff || rsp_ready))
      else $error("result word overwritten while waiting");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      load_result |=> rsp_valid)
      else $error("field end gave no result word");

   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.overflowed) |-> (mag_ff == fdp_pkg::ACC_MAX))
      else $error("overflow flag without saturated magnitude");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int FIELD_LEN   = 16;
   localparam int WORD_TARGET = 1850;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 10;

   typedef logic [fdp_pkg::CHAR_W-1:0] char_q_type[$];

   class decimal_scoreboard;
      bit                        minus_seen;
      bit                        digit_seen;
      bit                        parse_stopped;
      bit                        field_full;
      logic [3:0]                char_pos;
      logic [4:0]                point_pos;
      logic [3:0]                last_digit_pos;
      logic [fdp_pkg::ACC_W-1:0] acc;
      bit                        acc_saturated;
      fdp_pkg::rsp_type          pending[$];
      int                        errors;
      int                        fields;
      int                        results;
      int                        neg_fields;
      int                        scaled_fields;

      function new();
         errors        = 0;
         fields        = 0;
         results       = 0;
         neg_fields    = 0;
         scaled_fields = 0;
         clear_field();
      endfunction

      function void clear_field();
         minus_seen     = 0;
         digit_seen     = 0;
         parse_stopped  = 0;
         field_full     = 0;
         char_pos       = '0;
         point_pos      = 5'(FIELD_LEN);
         last_digit_pos = '0;
         acc            = '0;
         acc_saturated  = 0;
      endfunction

      // fold one accepted character word into the field, queue a result on field_end
      function void note_word(fdp_pkg::req_type w);
         logic [fdp_pkg::DIGIT_W-1:0] d;
         fdp_pkg::rsp_type            r;
         if (!field_full && !parse_stopped) begin
            if (w.char_code == fdp_pkg::CHAR_MINUS) begin
               minus_seen = 1;
            end else if (w.char_code == fdp_pkg::CHAR_POINT) begin
               point_pos = {1'b0, char_pos};
            end else if (w.char_code >= fdp_pkg::CHAR_ZERO &&
                         w.char_code <= fdp_pkg::CHAR_NINE) begin
               d = w.char_code[fdp_pkg::DIGIT_W-1:0];
               if (acc_saturated ||
                   acc > (fdp_pkg::ACC_MAX - fdp_pkg::ACC_W'(d)) / fdp_pkg::ACC_W'(10)) begin
                  acc           = fdp_pkg::ACC_MAX;
                  acc_saturated = 1;
               end else begin
                  acc = acc * fdp_pkg::ACC_W'(10) + fdp_pkg::ACC_W'(d);
               end
               digit_seen     = 1;
               last_digit_pos = char_pos;
            end else if (digit_seen) begin
               parse_stopped = 1;
            end
            if (char_pos == 4'(FIELD_LEN - 1)) field_full = 1;
            else char_pos = char_pos + 4'd1;
         end
         if (w.field_end) begin
            r = '0;
            if (digit_seen) begin
               r.mantissa = minus_seen ? -{1'b0, acc} : {1'b0, acc};
               // point after the last digit, or none at all, gives scale 0
               if (point_pos < {1'b0, last_digit_pos})
                  r.frac_scale = last_digit_pos - point_pos[3:0];
               r.overflowed = acc_saturated;
               if (minus_seen) neg_fields++;
               if (r.frac_scale != 0) scaled_fields++;
            end
            pending.push_back(r);
            fields++;
            clear_field();
         end
      endfunction

      function void check_word(fdp_pkg::rsp_type got);
         fdp_pkg::rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result word mantissa %0d scale %0d ovf %0b",
                     $time, got.mantissa, got.frac_scale, got.overflowed);
            errors++;
            return;
         end
         want = pending.pop_front();
         results++;
         if (got.mantissa !== want.mantissa) begin
            $display("%0t: mantissa expected %0d got %0d", $time, want.mantissa, got.mantissa);
            errors++;
         end
         if (got.frac_scale !== want.frac_scale) begin
            $display("%0t: frac_scale expected %0d got %0d",
                     $time, want.frac_scale, got.frac_scale);
            errors++;
         end
         if (got.overflowed !== want.overflowed) begin
            $display("%0t: overflowed expected %0b got %0b",
                     $time, want.overflowed, got.overflowed);
            errors++;
         end
      endfunction
   endclass

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   fdp_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   fdp_pkg::rsp_type rsp_data;

   decimal_scoreboard sb = new();

   bit quiet         = 0;
   bit sender_burst  = 0;
   int hold_reqs     = 0;
   int cycle_count   = 0;
   int words_sent    = 0;
   int stall_cycles  = 0;

   fixed_field_decimal_parser_unit #(
      .MAX_FIELD_LEN(FIELD_LEN)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (req_valid && !req_ready) stall_cycles <= stall_cycles + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   function automatic logic [fdp_pkg::CHAR_W-1:0] junk_char();
      logic [fdp_pkg::CHAR_W-1:0] c;
      if ($urandom_range(0, 9) < 3) return 8'h20;
      do begin
         c = fdp_pkg::CHAR_W'($urandom_range(0, 255));
      end while ((c >= fdp_pkg::CHAR_ZERO && c <= fdp_pkg::CHAR_NINE) ||
                 c == fdp_pkg::CHAR_MINUS || c == fdp_pkg::CHAR_POINT);
      return c;
   endfunction

   function automatic logic [fdp_pkg::CHAR_W-1:0] digit_char();
      return fdp_pkg::CHAR_ZERO + fdp_pkg::CHAR_W'($urandom_range(0, 9));
   endfunction

   function automatic char_q_type make_field();
      char_q_type q;
      int         kind;
      kind = $urandom_range(0, 99);
      if (kind < 4) begin
         // widest mantissa, sometimes running past the field width
         if ($urandom_range(0, 1)) q.push_back(fdp_pkg::CHAR_MINUS);
         repeat ($urandom_range(16, 18)) q.push_back(fdp_pkg::CHAR_NINE);
      end else if (kind < 72) begin
         repeat ($urandom_range(0, 2)) q.push_back(junk_char());
         if ($urandom_range(0, 1)) q.push_back(fdp_pkg::CHAR_MINUS);
         repeat ($urandom_range(0, 7)) q.push_back(digit_char());
         if ($urandom_range(0, 9) < 6) begin
            q.push_back(fdp_pkg::CHAR_POINT);
            repeat ($urandom_range(0, 6)) q.push_back(digit_char());
         end
         repeat ($urandom_range(0, 3))
            q.push_back(($urandom_range(0, 3) == 0) ? digit_char() : junk_char());
      end else if (kind < 86) begin
         repeat ($urandom_range(1, 20))
            q.push_back(fdp_pkg::CHAR_W'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 20)) begin
            case ($urandom_range(0, 3))
               0: q.push_back(fdp_pkg::CHAR_MINUS);
               1: q.push_back(fdp_pkg::CHAR_POINT);
               2: q.push_back(digit_char());
               default: q.push_back(junk_char());
            endcase
         end
      end
      if (q.size() == 0) q.push_back(junk_char());
      return q;
   endfunction

   task automatic send_field(input char_q_type chars);
      fdp_pkg::req_type w;
      int               gap;
      for (int i = 0; i < chars.size(); i++) begin
         w.char_code = chars[i];
         w.field_end = (i == chars.size() - 1);
         req_valid <= 1'b1;
         req_data  <= w;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         sb.note_word(w);
         words_sent++;
         gap = (quiet || sender_burst) ? 0 : pick_gap();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_text(input string s);
      char_q_type q;
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      send_field(q);
   endtask

   // sender pauses until every queued result has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   // result side: checks each accepted word and applies back-pressure
   initial begin : rsp_side
      int low_left;
      int hold_left;
      int hold_done;
      low_left  = 0;
      hold_left = 0;
      hold_done = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_word(rsp_data);
         if (hold_reqs != hold_done) begin
            hold_done = hold_reqs;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (reset) begin
            rsp_ready <= 1'b0;
         end else if (low_left > 0) begin
            low_left--;
            rsp_ready <= 1'b0;
         end else if (quiet) begin
            rsp_ready <= 1'b1;
         end else begin
            low_left = pick_gap();
            if (low_left == 0) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b0;
               low_left--;
            end
         end
      end
   end

   initial begin : req_side
      char_q_type q;
      int         field_idx;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: sign with zero, trailing point, leading point, stop after digit,
      // no digits, byte extremes, minus after digits, a later point replacing one
      send_text("-0.5");
      send_text("12.");
      send_text(".25");
      send_text("x7a8");
      send_text("-");
      q = {8'hFF, 8'h00};
      send_field(q);
      send_text("1-2");
      send_text("9.1.2");
      drain();

      field_idx = 0;
      while (words_sent < WORD_TARGET) begin
         if (field_idx == 40) begin
            // long receiver hold while the sender keeps pushing
            hold_reqs <= hold_reqs + 1;
            sender_burst = 1;
         end
         if (field_idx == 90) sender_burst = 0;
         if (field_idx == 120 || field_idx == 320) drain();
         quiet = (field_idx >= 160 && field_idx < 210);
         send_field(make_field());
         field_idx++;
      end
      quiet = 0;
      req_valid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d character words in %0d fields, %0d results checked.",
               words_sent, sb.fields, sb.results);
      $display("%0d negative, %0d with a fractional scale, %0d input stall cycles.",
               sb.neg_fields, sb.scaled_fields, stall_cycles);
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
